FILE: rtl/ffsa_pkg.sv
// Shared constants and types for the first-fit shard allocator.
package ffsa_pkg;

  localparam int unsigned MaxShards = 16;
  localparam int unsigned IdSpace   = 1024;
  localparam int unsigned IdW       = $clog2(IdSpace);
  localparam int unsigned ShardW    = 4;
  localparam int unsigned OpenW     = ShardW + 1;
  localparam int unsigned CntW      = 16;
  localparam int unsigned FuncW     = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned EntryW    = 1 + ShardW;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [CntW-1:0] CapacityReset = CntW'(1024);

  localparam logic RegCapacity = 1'b0;

  localparam logic [FuncW-1:0] FuncAdd = 2'd0;
  localparam logic [FuncW-1:0] FuncDel = 2'd1;

  localparam logic [StatusW-1:0] StPlaced  = 3'd0;
  localparam logic [StatusW-1:0] StOpened  = 3'd1;
  localparam logic [StatusW-1:0] StPresent = 3'd2;
  localparam logic [StatusW-1:0] StAbsent  = 3'd3;
  localparam logic [StatusW-1:0] StDeleted = 3'd4;
  localparam logic [StatusW-1:0] StFull    = 3'd5;

  typedef struct packed {
    logic              valid;
    logic [ShardW-1:0] shard;
  } entry_t;

endpackage

FILE: rtl/ffsa_if.sv
// Request and response channel interfaces of the shard allocator.
interface ffsa_req_if import ffsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [IdW-1:0]   item_id;

  modport source (output valid, func, item_id, input ready);
  modport sink (input valid, func, item_id, output ready);
endinterface

interface ffsa_rsp_if import ffsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ShardW-1:0]  shard_index;
  logic [StatusW-1:0] status;

  modport source (output valid, shard_index, status, input ready);
  modport sink (input valid, shard_index, status, output ready);
endinterface

FILE: rtl/ffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/first_fit_shard_allocator_unit.sv
// First-fit shard allocator: an id map in RAM, shard counters and a scan sequencer.
// Each request transaction yields one response transaction. A delete passes through the
// lookup and delete states before it answers, and an add through the lookup state and one
// scan step per open shard probed before a fit, each step waiting while the response
// register is full. A single counter compare scans the shards in order. An id found
// present on add, or absent on delete, answers from the lookup state. Clear, and the pass
// that follows reset, write the id map one entry a cycle over all 1024 entries, during
// which no request is accepted; the register port stays open. The request side is ready
// only while the sequencer is idle; a finished response may wait in its register while
// the next request is taken.
module first_fit_shard_allocator_unit import ffsa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ffsa_req_if.sink           req_i,
  ffsa_rsp_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [PdataW-1:0]  pwdata,
  output logic [PdataW-1:0]  prdata,
  output logic               pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [FuncW-1:0]   func_q, func_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [ShardW-1:0]  idx_q, idx_d;
  logic [OpenW-1:0]   open_q, open_d;
  logic [CntW-1:0]    counts_q [MaxShards];
  logic [CntW-1:0]    counts_d [MaxShards];
  logic [IdW-1:0]     clr_addr_q, clr_addr_d;
  logic               clr_rsp_q, clr_rsp_d;
  logic [CntW-1:0]    cap_q, cap_d;
  logic               out_vld_q, out_vld_d;
  logic [ShardW-1:0]  out_shard_q, out_shard_d;
  logic [StatusW-1:0] out_status_q, out_status_d;

  logic               ram_we;
  logic [IdW-1:0]     ram_waddr;
  logic [EntryW-1:0]  ram_wdata;
  logic               ram_re;
  logic [EntryW-1:0]  ram_rdata;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic [CntW-1:0]    cnt_sel;
  logic               emit_ok;
  logic               cfg_wr;

  ffsa_ram #(
    .Width (EntryW),
    .Depth (IdSpace)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (req_i.item_id),
    .rdata_o (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign cnt_sel   = counts_q[idx_q];
  assign emit_ok   = !out_vld_q || rsp_o.ready;
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == RegCapacity) ? PdataW'(cap_q) : '0;

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.shard_index = out_shard_q;
  assign rsp_o.status      = out_status_q;

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    id_d         = id_q;
    idx_d        = idx_q;
    open_d       = open_q;
    counts_d     = counts_q;
    clr_addr_d   = clr_addr_q;
    clr_rsp_d    = clr_rsp_q;
    cap_d        = cap_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_shard_d  = out_shard_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = id_q;
    wr_entry     = '0;
    ram_re       = 1'b0;

    if (cfg_wr && paddr[2] == RegCapacity) begin
      cap_d = pwdata[CntW-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d = req_i.func;
          id_d   = req_i.item_id;
          if (req_i.func[1]) begin
            for (int i = 0; i < MaxShards; i++) begin
              counts_d[i] = '0;
            end
            open_d     = '0;
            clr_addr_d = '0;
            clr_rsp_d  = 1'b1;
            state_d    = S_CLR;
          end else begin
            ram_re  = 1'b1;
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (emit_ok) begin
          if (func_q == FuncDel) begin
            if (!rd_entry.valid) begin
              out_vld_d    = 1'b1;
              out_shard_d  = '0;
              out_status_d = StAbsent;
              state_d      = S_IDLE;
            end else begin
              idx_d   = rd_entry.shard;
              state_d = S_DEL;
            end
          end else if (rd_entry.valid) begin
            out_vld_d    = 1'b1;
            out_shard_d  = '0;
            out_status_d = StPresent;
            state_d      = S_IDLE;
          end else begin
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (emit_ok) begin
          wr_entry.valid = 1'b1;
          wr_entry.shard = idx_q;
          if ({1'b0, idx_q} < open_q) begin
            if (cnt_sel < cap_q) begin
              counts_d[idx_q] = cnt_sel + CntW'(1);
              ram_we          = 1'b1;
              out_vld_d       = 1'b1;
              out_shard_d     = idx_q;
              out_status_d    = StPlaced;
              state_d         = S_IDLE;
            end else if (idx_q == ShardW'(MaxShards - 1)) begin
              out_vld_d    = 1'b1;
              out_shard_d  = '0;
              out_status_d = StFull;
              state_d      = S_IDLE;
            end else begin
              idx_d = idx_q + ShardW'(1);
            end
          end else begin
            counts_d[idx_q] = CntW'(1);
            open_d          = open_q + OpenW'(1);
            ram_we          = 1'b1;
            out_vld_d       = 1'b1;
            out_shard_d     = idx_q;
            out_status_d    = StOpened;
            state_d         = S_IDLE;
          end
        end
      end
      S_DEL: begin
        if (emit_ok) begin
          if (cnt_sel != '0) begin
            counts_d[idx_q] = cnt_sel - CntW'(1);
          end
          ram_we       = 1'b1;
          out_vld_d    = 1'b1;
          out_shard_d  = idx_q;
          out_status_d = StDeleted;
          state_d      = S_IDLE;
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        if (clr_addr_q == IdW'(IdSpace - 1)) begin
          if (!clr_rsp_q) begin
            state_d = S_IDLE;
          end else if (emit_ok) begin
            out_vld_d    = 1'b1;
            out_shard_d  = '0;
            out_status_d = StFull;
            clr_rsp_d    = 1'b0;
            state_d      = S_IDLE;
          end
        end else begin
          clr_addr_d = clr_addr_q + IdW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    ram_wdata = wr_entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      open_q     <= '0;
      clr_addr_q <= '0;
      clr_rsp_q  <= 1'b0;
      cap_q      <= CapacityReset;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < MaxShards; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      open_q     <= open_d;
      clr_addr_q <= clr_addr_d;
      clr_rsp_q  <= clr_rsp_d;
      cap_q      <= cap_d;
      out_vld_q  <= out_vld_d;
      counts_q   <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    id_q         <= id_d;
    idx_q        <= idx_d;
    out_shard_q  <= out_shard_d;
    out_status_q <= out_status_d;
  end

endmodule

FILE: verif/tb.sv
// Testbench for the shard allocator: directed table plus random phases, predictor checked.
module tb;
  import ffsa_pkg::*;

  localparam logic [FuncW-1:0] FuncClr = 2'd2;
  localparam logic [FuncW-1:0] FuncRsv = 2'd3;
  localparam logic [PaddrW-1:0] CapAddr = {RegCapacity, 2'b00};
  localparam int unsigned Phases = 8;
  localparam int unsigned PhaseItems = 56;
  localparam int unsigned DirRows = 24;

  typedef struct packed {
    logic [ShardW-1:0]  shard;
    logic [StatusW-1:0] status;
  } outcome_t;

  typedef struct packed {
    logic               set_cap;
    logic [CntW-1:0]    cap;
    logic [FuncW-1:0]   func;
    logic [IdW-1:0]     id;
    logic               typed;
    logic [ShardW-1:0]  shard;
    logic [StatusW-1:0] status;
  } dir_row_t;

  localparam dir_row_t DirTable [DirRows] = '{
    '{1'b0, 16'd0, FuncDel, 10'd0, 1'b1, 4'd0, StAbsent},
    '{1'b0, 16'd0, FuncAdd, 10'd0, 1'b1, 4'd0, StOpened},
    '{1'b0, 16'd0, FuncAdd, 10'd0, 1'b1, 4'd0, StPresent},
    '{1'b0, 16'd0, FuncAdd, 10'd1023, 1'b1, 4'd0, StPlaced},
    '{1'b0, 16'd0, FuncDel, 10'd1023, 1'b1, 4'd0, StDeleted},
    '{1'b0, 16'd0, FuncDel, 10'd1023, 1'b1, 4'd0, StAbsent},
    '{1'b0, 16'd0, FuncClr, 10'd1023, 1'b1, 4'd0, StFull},
    '{1'b0, 16'd0, FuncDel, 10'd0, 1'b1, 4'd0, StAbsent},
    '{1'b1, 16'd1, FuncAdd, 10'd5, 1'b1, 4'd0, StOpened},
    '{1'b0, 16'd0, FuncAdd, 10'd6, 1'b1, 4'd1, StOpened},
    '{1'b0, 16'd0, FuncAdd, 10'd7, 1'b1, 4'd2, StOpened},
    '{1'b0, 16'd0, FuncDel, 10'd6, 1'b1, 4'd1, StDeleted},
    '{1'b0, 16'd0, FuncAdd, 10'd8, 1'b1, 4'd1, StPlaced},
    '{1'b0, 16'd0, FuncRsv, 10'h2AA, 1'b1, 4'd0, StFull},
    '{1'b1, 16'd0, FuncAdd, 10'h155, 1'b1, 4'd0, StOpened},
    '{1'b0, 16'd0, FuncAdd, 10'h2AA, 1'b1, 4'd1, StOpened},
    '{1'b0, 16'd0, FuncAdd, 10'h155, 1'b1, 4'd0, StPresent},
    '{1'b0, 16'd0, FuncDel, 10'h2AA, 1'b1, 4'd1, StDeleted},
    '{1'b0, 16'd0, FuncAdd, 10'h3FF, 1'b0, 4'd0, StPlaced},
    '{1'b1, 16'hFFFF, FuncClr, 10'd0, 1'b1, 4'd0, StFull},
    '{1'b0, 16'd0, FuncAdd, 10'd1, 1'b1, 4'd0, StOpened},
    '{1'b0, 16'd0, FuncAdd, 10'd2, 1'b1, 4'd0, StPlaced},
    '{1'b0, 16'd0, FuncDel, 10'd1, 1'b1, 4'd0, StDeleted},
    '{1'b0, 16'd0, FuncAdd, 10'd512, 1'b0, 4'd0, StPlaced}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  ffsa_req_if req_if ();
  ffsa_rsp_if rsp_if ();

  first_fit_shard_allocator_unit u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // predictor state
  logic              owned [IdSpace];
  logic [ShardW-1:0] owner_of [IdSpace];
  logic [CntW-1:0]   fill [MaxShards];
  int unsigned       shards_open;
  logic [CntW-1:0]   capacity;

  outcome_t    pending_outcomes [$];
  int          mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;

  function automatic outcome_t first_fit_outcome(input logic [FuncW-1:0] func,
                                                 input logic [IdW-1:0] id);
    outcome_t    o;
    int unsigned s;
    logic        done;
    o = '{shard: '0, status: StFull};
    if (func[1]) begin
      // reserved code decodes as clear
      owned = '{default: 1'b0};
      owner_of = '{default: '0};
      fill = '{default: '0};
      shards_open = 0;
    end else if (func == FuncDel) begin
      if (!owned[id]) begin
        o.status = StAbsent;
      end else begin
        s = int'(owner_of[id]);
        if (fill[s] != 0) fill[s] = fill[s] - CntW'(1);
        owned[id] = 1'b0;
        owner_of[id] = '0;
        o = '{shard: ShardW'(s), status: StDeleted};
      end
    end else begin
      if (owned[id]) begin
        o.status = StPresent;
      end else begin
        done = 1'b0;
        for (s = 0; s < shards_open && !done; s++) begin
          if (fill[s] < capacity) begin
            fill[s] = fill[s] + CntW'(1);
            owned[id] = 1'b1;
            owner_of[id] = ShardW'(s);
            o = '{shard: ShardW'(s), status: StPlaced};
            done = 1'b1;
          end
        end
        if (!done && shards_open < MaxShards) begin
          s = shards_open;
          fill[s] = CntW'(1);
          shards_open = s + 1;
          owned[id] = 1'b1;
          owner_of[id] = ShardW'(s);
          o = '{shard: ShardW'(s), status: StOpened};
        end
      end
    end
    return o;
  endfunction

  task automatic send_request(input logic [FuncW-1:0] func, input logic [IdW-1:0] id,
                              input logic typed, input outcome_t typed_val);
    outcome_t o;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func <= func;
    req_if.item_id <= id;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    o = first_fit_outcome(func, id);
    pending_outcomes = {pending_outcomes, (typed ? typed_val : o)};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // write then read back; upper data bits are don't-care on write
  task automatic set_capacity(input logic [CntW-1:0] cap);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CapAddr;
    pwdata <= {16'($urandom), cap};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    capacity = cap;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== PdataW'(cap)) begin
      mismatch_count++;
      $display("%0t: prdata expected %0h actual %0h", $time, PdataW'(cap), prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction shard_index %0d status %0d", $time,
                 rsp_if.shard_index, rsp_if.status);
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_if.shard_index !== want.shard) begin
          mismatch_count++;
          $display("%0t: shard_index expected %0d actual %0d", $time, want.shard,
                   rsp_if.shard_index);
        end
        if (rsp_if.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
        end
      end
    end
  end

  initial begin
    #(12 * 4000000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [CntW-1:0]  phase_cap [Phases];
    logic [FuncW-1:0] func;
    logic [IdW-1:0]   id;
    int unsigned      r;
    int unsigned      pool_hi;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.func = FuncAdd;
    req_if.item_id = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    sender_idle_pct = 29;
    recv_stall_pct = 29;
    owned = '{default: 1'b0};
    owner_of = '{default: '0};
    fill = '{default: '0};
    shards_open = 0;
    capacity = CapacityReset;
    phase_cap = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd3, 16'd1, 16'd5, 16'd1024};
    phase_cap[Phases-1] = CntW'($urandom_range(1, 8));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DirTable[i]) begin
      if (DirTable[i].set_cap) begin
        wait_drained();
        set_capacity(DirTable[i].cap);
      end
      send_request(DirTable[i].func, DirTable[i].id, DirTable[i].typed,
                   '{shard: DirTable[i].shard, status: DirTable[i].status});
    end

    for (int p = 0; p < Phases; p++) begin
      wait_drained();
      set_capacity(phase_cap[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
        1: begin sender_idle_pct = 84; recv_stall_pct = 0; end
        2: begin sender_idle_pct = 0; recv_stall_pct = 84; end
        default: begin sender_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      pool_hi = (p % 2) ? 31 : 63;
      for (int n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(99);
        if (r < 2) func = FuncClr;
        else if (r < 4) func = FuncRsv;
        else if (r < 62) func = FuncAdd;
        else func = FuncDel;
        r = $urandom_range(99);
        if (r < 70) begin
          id = IdW'($urandom_range(pool_hi));
        end else if (r < 90) begin
          id = IdW'($urandom_range(IdSpace - 1));
        end else begin
          case ($urandom_range(3))
            0: id = '0;
            1: id = '1;
            2: id = 10'h155;
            default: id = 10'h2AA;
          endcase
        end
        send_request(func, id, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
